### hdl/u8vsc_pkg.sv
// Shared types and constants for the UTF-8 validate and space collapse block.
// No dependencies; every other file of the block but the queue refers to this package.
`timescale 1ns / 1ps
`default_nettype none

package u8vsc_pkg;

   // Result kinds.
   localparam logic [1:0] KIND_DATA   = 2'd0;
   localparam logic [1:0] KIND_DONE   = 2'd1;
   localparam logic [1:0] KIND_REJECT = 2'd2;

   // Error codes.
   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_CONTROL   = 3'd1;
   localparam logic [2:0] ERR_INVALID   = 3'd2;
   localparam logic [2:0] ERR_TRUNCATED = 3'd3;
   localparam logic [2:0] ERR_NONSCALAR = 3'd4;
   localparam logic [2:0] ERR_TOO_LONG  = 3'd5;
   localparam logic [2:0] ERR_BLANK     = 3'd6;

   // Configuration register indexes.
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MAX_SCALARS = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MAX_BYTES   = 2'd1;
   localparam int CSR_DATA_BITS = 16;
   localparam logic [CSR_DATA_BITS-1:0] MAX_SCALARS_RESET = 16'd1000;
   localparam logic [CSR_DATA_BITS-1:0] MAX_BYTES_RESET   = 16'd4096;

   localparam int COUNT_BITS_DEFAULT = 16;
   localparam int QUEUE_DEPTH        = 2;

   // Byte values used by the decoder.
   localparam logic [7:0] ASCII_MAX   = 8'h7F;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] LEAD2_MIN   = 8'hC2;
   localparam logic [7:0] LEAD2_MAX   = 8'hDF;
   localparam logic [7:0] LEAD3_MIN   = 8'hE0;
   localparam logic [7:0] LEAD3_MAX   = 8'hEF;
   localparam logic [7:0] LEAD4_MIN   = 8'hF0;
   localparam logic [7:0] LEAD4_MAX   = 8'hF4;
   localparam logic [7:0] LEAD_SURR   = 8'hED;
   localparam logic [7:0] CONT_MAX    = 8'hBF;
   localparam logic [7:0] E0_SECOND_MIN = 8'hA0;
   localparam logic [7:0] ED_SECOND_MAX = 8'h9F;
   localparam logic [7:0] F0_SECOND_MIN = 8'h90;
   localparam logic [7:0] F4_SECOND_MAX = 8'h8F;
   localparam logic [7:0] C1_SECOND_MAX = 8'h9F;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [7:0]  data_byte;
      logic [2:0]  error_code;
      logic [15:0] scalar_total;
      logic [15:0] byte_total;
      logic        last_of_run;
   } rsp_type;

   // Work handed from the decoder to the emitter for one input byte.
   typedef struct packed {
      logic            space;
      logic [2:0]      nbytes;
      logic [3:0][7:0] bytes;
      logic            has_term;
      logic [1:0]      term_kind;
      logic [2:0]      error_code;
   } job_type;

endpackage

`default_nettype wire

### hdl/u8vsc_front.sv
// Decoder front end: configuration registers, UTF-8 sequence tracking,
// whitespace folding, limit checks. Builds at most one job per byte. Uses u8vsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u8vsc_front #(
   parameter int COUNT_BITS = u8vsc_pkg::COUNT_BITS_DEFAULT
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire u8vsc_pkg::req_type                     req_item,
   input  wire logic                                   csr_valid,
   input  wire logic [u8vsc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [u8vsc_pkg::CSR_DATA_BITS-1:0]    csr_data,
   input  wire logic                                   queue_full,
   output logic                                        job_push,
   output u8vsc_pkg::job_type                          job_ctl,
   output logic [COUNT_BITS-1:0]                       job_scalar,
   output logic [COUNT_BITS-1:0]                       job_byte
);

   localparam int CMP_W = (COUNT_BITS + 1 > 17) ? COUNT_BITS + 1 : 17;

   logic [15:0]           max_scalars_ff;
   logic [15:0]           max_bytes_ff;
   logic                  space_pending_ff, space_pending_in;
   logic [2:0][7:0]       store_ff, store_in;
   logic [2:0]            seq_len_ff, seq_len_in;
   logic [1:0]            seq_pos_ff, seq_pos_in;
   logic                  bad_cont_ff, bad_cont_in;
   logic [COUNT_BITS-1:0] scalar_ff, scalar_in;
   logic [COUNT_BITS-1:0] byte_ff, byte_in;
   logic                  discard_ff, discard_in;

   logic                  fire;
   logic [7:0]            b;
   logic                  eot;
   logic                  is_cont;
   logic                  bad;
   logic [2:0]            pos_next;
   logic [2:0]            len;
   logic [3:0][7:0]       seq_bytes;
   logic [7:0]            lead;
   logic [7:0]            second;
   logic [2:0]            err;
   logic [CMP_W-1:0]      ns;
   logic [CMP_W-1:0]      nb;
   logic                  over;
   logic                  sp_emit;
   logic [2:0]            len_emit;
   logic                  term;
   logic [1:0]            term_kind;
   logic [2:0]            term_err;
   logic                  do_clear;

   assign req_ready = !queue_full;
   assign fire      = req_valid && req_ready;
   assign b         = req_item.in_byte;
   assign eot       = req_item.end_of_text;
   assign is_cont   = (b[7:6] == 2'b10);

   always_comb begin
      space_pending_in = space_pending_ff;
      store_in         = store_ff;
      seq_len_in       = seq_len_ff;
      seq_pos_in       = seq_pos_ff;
      bad_cont_in      = bad_cont_ff;
      scalar_in        = scalar_ff;
      byte_in          = byte_ff;
      discard_in       = discard_ff;
      bad              = 1'b0;
      pos_next         = {1'b0, seq_pos_ff} + 3'd1;
      len              = 3'd0;
      seq_bytes        = '0;
      lead             = 8'h00;
      second           = 8'h00;
      err              = u8vsc_pkg::ERR_NONE;
      ns               = '0;
      nb               = '0;
      over             = 1'b0;
      sp_emit          = 1'b0;
      len_emit         = 3'd0;
      term             = 1'b0;
      term_kind        = u8vsc_pkg::KIND_DATA;
      term_err         = u8vsc_pkg::ERR_NONE;
      do_clear         = 1'b0;

      if (discard_ff) begin
         do_clear = eot;
      end else begin
         if (seq_len_ff != 3'd0) begin
            bad = bad_cont_ff | ~is_cont;
            if (seq_pos_ff != 2'd3) begin
               store_in[seq_pos_ff] = b;
            end
            if (pos_next >= seq_len_ff) begin
               len          = seq_len_ff;
               seq_bytes[0] = store_ff[0];
               seq_bytes[1] = (len == 3'd2) ? b : store_ff[1];
               seq_bytes[2] = (len == 3'd3) ? b : store_ff[2];
               seq_bytes[3] = b;
               lead         = seq_bytes[0];
               second       = seq_bytes[1];
               seq_len_in   = 3'd0;
               seq_pos_in   = 2'd0;
               bad_cont_in  = 1'b0;
               if (bad) begin
                  err = u8vsc_pkg::ERR_INVALID;
               end else if ((len == 3'd3 && lead == u8vsc_pkg::LEAD3_MIN &&
                             second < u8vsc_pkg::E0_SECOND_MIN) ||
                            (len == 3'd3 && lead == u8vsc_pkg::LEAD_SURR &&
                             second > u8vsc_pkg::ED_SECOND_MAX) ||
                            (len == 3'd4 && lead == u8vsc_pkg::LEAD4_MIN &&
                             second < u8vsc_pkg::F0_SECOND_MIN) ||
                            (len == 3'd4 && lead == u8vsc_pkg::LEAD4_MAX &&
                             second > u8vsc_pkg::F4_SECOND_MAX)) begin
                  err = u8vsc_pkg::ERR_NONSCALAR;
               end else if (len == 3'd2 && lead == u8vsc_pkg::LEAD2_MIN &&
                            second <= u8vsc_pkg::C1_SECOND_MAX) begin
                  err = u8vsc_pkg::ERR_CONTROL;
               end
            end else begin
               seq_pos_in  = pos_next[1:0];
               bad_cont_in = bad;
            end
         end else if (b <= u8vsc_pkg::ASCII_MAX) begin
            if (b == u8vsc_pkg::CHAR_SPACE || b == u8vsc_pkg::CHAR_TAB ||
                b == u8vsc_pkg::CHAR_LF || b == u8vsc_pkg::CHAR_CR) begin
               if (byte_ff != '0) begin
                  space_pending_in = 1'b1;
               end
            end else if (b < u8vsc_pkg::CHAR_SPACE || b == u8vsc_pkg::ASCII_MAX) begin
               err = u8vsc_pkg::ERR_CONTROL;
            end else begin
               len          = 3'd1;
               seq_bytes[0] = b;
            end
         end else if (b >= u8vsc_pkg::LEAD2_MIN && b <= u8vsc_pkg::LEAD2_MAX) begin
            store_in[0] = b;
            seq_len_in  = 3'd2;
            seq_pos_in  = 2'd1;
            bad_cont_in = 1'b0;
         end else if (b >= u8vsc_pkg::LEAD3_MIN && b <= u8vsc_pkg::LEAD3_MAX) begin
            store_in[0] = b;
            seq_len_in  = 3'd3;
            seq_pos_in  = 2'd1;
            bad_cont_in = 1'b0;
         end else if (b >= u8vsc_pkg::LEAD4_MIN && b <= u8vsc_pkg::LEAD4_MAX) begin
            store_in[0] = b;
            seq_len_in  = 3'd4;
            seq_pos_in  = 2'd1;
            bad_cont_in = 1'b0;
         end else begin
            err = u8vsc_pkg::ERR_INVALID;
         end

         // A finished scalar is emitted only if it and its pending space fit
         // both the configured limits and the counter range.
         if (err == u8vsc_pkg::ERR_NONE && len != 3'd0) begin
            ns = CMP_W'(scalar_ff) + CMP_W'(space_pending_ff) + CMP_W'(1);
            nb = CMP_W'(byte_ff) + CMP_W'(space_pending_ff) + CMP_W'(len);
            over = (ns > CMP_W'(max_scalars_ff)) || (nb > CMP_W'(max_bytes_ff)) ||
                   ((ns >> COUNT_BITS) != '0) || ((nb >> COUNT_BITS) != '0);
            if (over) begin
               err = u8vsc_pkg::ERR_TOO_LONG;
            end else begin
               sp_emit          = space_pending_ff;
               len_emit         = len;
               scalar_in        = COUNT_BITS'(ns);
               byte_in          = COUNT_BITS'(nb);
               space_pending_in = 1'b0;
            end
         end

         if (err == u8vsc_pkg::ERR_NONE && eot && seq_len_in != 3'd0) begin
            err = u8vsc_pkg::ERR_TRUNCATED;
         end

         if (err != u8vsc_pkg::ERR_NONE) begin
            term      = 1'b1;
            term_kind = u8vsc_pkg::KIND_REJECT;
            term_err  = err;
            do_clear  = 1'b1;
         end else if (eot) begin
            term     = 1'b1;
            do_clear = 1'b1;
            if (byte_in == '0) begin
               term_kind = u8vsc_pkg::KIND_REJECT;
               term_err  = u8vsc_pkg::ERR_BLANK;
            end else begin
               term_kind = u8vsc_pkg::KIND_DONE;
            end
         end
      end

      if (do_clear) begin
         space_pending_in = 1'b0;
         seq_len_in       = 3'd0;
         seq_pos_in       = 2'd0;
         bad_cont_in      = 1'b0;
         scalar_in        = '0;
         byte_in          = '0;
         // An error mid-text drops the rest of it up to the end mark.
         discard_in       = !discard_ff && term && (term_err != u8vsc_pkg::ERR_NONE) &&
                            (term_kind == u8vsc_pkg::KIND_REJECT) && !eot &&
                            (err != u8vsc_pkg::ERR_NONE);
      end
   end

   always_comb begin
      job_ctl.space      = sp_emit;
      job_ctl.nbytes     = len_emit;
      job_ctl.bytes      = seq_bytes;
      job_ctl.has_term   = term;
      job_ctl.term_kind  = term_kind;
      job_ctl.error_code = term_err;
      job_scalar         = scalar_ff;
      job_byte           = byte_ff;
      job_push           = fire && (sp_emit || (len_emit != 3'd0) || term);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_scalars_ff <= u8vsc_pkg::MAX_SCALARS_RESET;
         max_bytes_ff   <= u8vsc_pkg::MAX_BYTES_RESET;
      end else if (csr_valid) begin
         if (csr_index == u8vsc_pkg::REG_MAX_SCALARS) begin
            max_scalars_ff <= csr_data;
         end else if (csr_index == u8vsc_pkg::REG_MAX_BYTES) begin
            max_bytes_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         space_pending_ff <= 1'b0;
         seq_len_ff       <= 3'd0;
         seq_pos_ff       <= 2'd0;
         bad_cont_ff      <= 1'b0;
         scalar_ff        <= '0;
         byte_ff          <= '0;
         discard_ff       <= 1'b0;
      end else if (fire) begin
         space_pending_ff <= space_pending_in;
         seq_len_ff       <= seq_len_in;
         seq_pos_ff       <= seq_pos_in;
         bad_cont_ff      <= bad_cont_in;
         scalar_ff        <= scalar_in;
         byte_ff          <= byte_in;
         discard_ff       <= discard_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         store_ff <= store_in;
      end
   end

endmodule

`default_nettype wire

### hdl/u8vsc_queue.sv
// Small first-in first-out queue of decoder jobs between front and back end.
// Generic payload width; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module u8vsc_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic                  full,
   output logic                  not_empty,
   output logic [WIDTH-1:0]      head_data
);

   localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W    = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    entry_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0]  count_ff, count_in;

   assign full      = (count_ff == COUNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### hdl/u8vsc_back.sv
// Emitter back end: walks one job result by result into the output register.
// Uses u8vsc_pkg for the job and result types.
`timescale 1ns / 1ps
`default_nettype none

module u8vsc_back #(
   parameter int COUNT_BITS = u8vsc_pkg::COUNT_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  job_valid,
   input  wire u8vsc_pkg::job_type    job_ctl,
   input  wire logic [COUNT_BITS-1:0] job_scalar,
   input  wire logic [COUNT_BITS-1:0] job_byte,
   output logic                       job_pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output u8vsc_pkg::rsp_type         rsp_item
);

   logic [2:0]            step_ff, step_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   u8vsc_pkg::rsp_type    rsp_ff, rsp_in;

   logic                  out_free;
   logic                  advance;
   logic [2:0]            total;
   logic [2:0]            data_idx;
   logic                  last;
   logic [COUNT_BITS-1:0] sp_count;
   logic [COUNT_BITS-1:0] cur_scalar;
   logic [COUNT_BITS-1:0] cur_byte;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign advance  = job_valid && out_free;
   assign total    = 3'(job_ctl.space) + job_ctl.nbytes + 3'(job_ctl.has_term);
   assign data_idx = step_ff - 3'(job_ctl.space);
   assign last     = (step_ff == total - 3'd1);
   assign sp_count = COUNT_BITS'(job_ctl.space);

   always_comb begin
      rsp_in              = rsp_ff;
      rsp_in.data_byte    = 8'h00;
      rsp_in.error_code   = u8vsc_pkg::ERR_NONE;
      rsp_in.last_of_run  = last;
      cur_scalar          = job_scalar;
      cur_byte            = job_byte;
      // Order within one job: pending space, scalar bytes, then the end result.
      if (job_ctl.space && step_ff == 3'd0) begin
         rsp_in.result_kind = u8vsc_pkg::KIND_DATA;
         rsp_in.data_byte   = u8vsc_pkg::CHAR_SPACE;
         cur_scalar         = job_scalar + COUNT_BITS'(1);
         cur_byte           = job_byte + COUNT_BITS'(1);
      end else if (data_idx < job_ctl.nbytes) begin
         rsp_in.result_kind = u8vsc_pkg::KIND_DATA;
         rsp_in.data_byte   = job_ctl.bytes[data_idx[1:0]];
         cur_scalar         = job_scalar + sp_count + COUNT_BITS'(1);
         cur_byte           = job_byte + sp_count + COUNT_BITS'(data_idx) + COUNT_BITS'(1);
      end else begin
         rsp_in.result_kind = job_ctl.term_kind;
         rsp_in.error_code  = job_ctl.error_code;
         cur_scalar         = job_scalar + sp_count + COUNT_BITS'(job_ctl.nbytes != 3'd0);
         cur_byte           = job_byte + sp_count + COUNT_BITS'(job_ctl.nbytes);
      end
      rsp_in.scalar_total = 16'(cur_scalar);
      rsp_in.byte_total   = 16'(cur_byte);

      rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);
      step_in      = step_ff;
      if (advance) begin
         step_in = last ? 3'd0 : step_ff + 3'd1;
      end
   end

   assign job_pop   = advance && last;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire

### hdl/utf8_validate_space_collapse_top.sv
// Top level of the UTF-8 validate and space collapse block.
// Instantiates u8vsc_front, u8vsc_queue and u8vsc_back; uses u8vsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Accepts one text byte per cycle and checks strict UTF-8, folds each run of
// whitespace into a single space with none at either end, and enforces the
// max_scalars and max_bytes limits. Every byte is decoded in the cycle it is
// accepted; the results it causes (a space, up to four scalar bytes, and a
// finish or reject) leave through the output register one per cycle unless
// stalled, so a byte completing a scalar after a space yields up to six results.
// A queue of QUEUE_DEPTH jobs between decoder and emitter absorbs such bursts;
// input stalls only when that queue is full. On a reject, all data already
// sent for that text must be dropped; the rest of the text up to its end
// mark is consumed silently. Configuration writes are always accepted and
// must be made only while the block is idle.
module utf8_validate_space_collapse_top #(
   parameter int COUNT_BITS = u8vsc_pkg::COUNT_BITS_DEFAULT
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire u8vsc_pkg::req_type                     req_item,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output u8vsc_pkg::rsp_type                          rsp_item,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [u8vsc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [u8vsc_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   localparam int JOB_W = $bits(u8vsc_pkg::job_type) + 2 * COUNT_BITS;

   logic                  queue_full;
   logic                  queue_not_empty;
   logic                  job_push;
   logic                  job_pop;
   u8vsc_pkg::job_type    push_ctl;
   logic [COUNT_BITS-1:0] push_scalar;
   logic [COUNT_BITS-1:0] push_byte;
   logic [JOB_W-1:0]      head_data;
   u8vsc_pkg::job_type    head_ctl;
   logic [COUNT_BITS-1:0] head_scalar;
   logic [COUNT_BITS-1:0] head_byte;

   assign csr_ready = 1'b1;

   u8vsc_front #(
      .COUNT_BITS (COUNT_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .queue_full (queue_full),
      .job_push   (job_push),
      .job_ctl    (push_ctl),
      .job_scalar (push_scalar),
      .job_byte   (push_byte)
   );

   u8vsc_queue #(
      .WIDTH (JOB_W),
      .DEPTH (u8vsc_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data ({push_ctl, push_scalar, push_byte}),
      .pop       (job_pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head_data (head_data)
   );

   assign {head_ctl, head_scalar, head_byte} = head_data;

   u8vsc_back #(
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (queue_not_empty),
      .job_ctl    (head_ctl),
      .job_scalar (head_scalar),
      .job_byte   (head_byte),
      .job_pop    (job_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_item   (rsp_item)
   );

endmodule

`default_nettype wire

### hdl/u8vsc_checker.sv
// Port-level checks for utf8_validate_space_collapse_top, bound to the top.
// Uses u8vsc_pkg for the result type and codes.
`timescale 1ns / 1ps
`default_nettype none

module u8vsc_port_assert (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire u8vsc_pkg::rsp_type rsp_item
);

   // A stalled result holds until its transfer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("result changed while stalled");

   // Finish and reject always close the run of results for their byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.result_kind != u8vsc_pkg::KIND_DATA |->
         rsp_item.last_of_run && rsp_item.data_byte == 8'h00)
      else $error("end result not last of run");

   // A reject carries a reason; data and finish carry none.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.result_kind == u8vsc_pkg::KIND_REJECT) ==
                    (rsp_item.error_code != u8vsc_pkg::ERR_NONE))
      else $error("error code does not match result kind");

   // Every data byte is counted, and a clean finish never reports an empty text.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.result_kind == u8vsc_pkg::KIND_DATA ||
                    rsp_item.result_kind == u8vsc_pkg::KIND_DONE) |->
         rsp_item.byte_total != 16'd0 && rsp_item.scalar_total != 16'd0)
      else $error("zero totals on data or finish");

endmodule

bind utf8_validate_space_collapse_top u8vsc_port_assert u_port_assert (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_item  (rsp_item)
);

`default_nettype wire

### tb/u8vsc_checker.sv
`timescale 1ns / 1ps
// Result checker for the UTF-8 validate and space collapse block.
// It watches the request, result and register ports, predicts results and compares them.
// Depends on u8vsc_pkg for the payload types, result kinds, error codes and register indexes.

module u8vsc_checker (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   input  wire logic                                 req_ready,
   input  wire u8vsc_pkg::req_type                   req_item,
   input  wire logic                                 rsp_valid,
   input  wire logic                                 rsp_ready,
   input  wire u8vsc_pkg::rsp_type                   rsp_item,
   input  wire logic                                 csr_valid,
   input  wire logic                                 csr_ready,
   input  wire logic [u8vsc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [u8vsc_pkg::CSR_DATA_BITS-1:0]  csr_data,
   output int                                        mismatch_count,
   output int                                        outstanding
);
   import u8vsc_pkg::*;

   localparam int REPORT_LIMIT  = 10;
   localparam int COUNT_CEILING = 65535;

   // Configuration copy.
   logic [15:0] lim_scalars;
   logic [15:0] lim_bytes;

   // Decoder state of the text in progress.
   logic        space_owed;
   logic [7:0]  seq_bytes [3];
   logic [2:0]  seq_len;
   logic [2:0]  seq_pos;
   logic        bad_cont;
   logic [15:0] scalar_cnt;
   logic [15:0] byte_cnt;
   logic        dropping;

   rsp_type run_buf [6];
   int      run_len;
   rsp_type normalized_results [$];
   rsp_type want;

   function automatic string describe(input rsp_type r);
      return $sformatf("kind %0d data %02h err %0d scalars %0d bytes %0d last %0b",
                       r.result_kind, r.data_byte, r.error_code, r.scalar_total,
                       r.byte_total, r.last_of_run);
   endfunction

   function automatic logic [7:0] in_range(input logic [7:0] b, input logic [7:0] lo,
                                           input logic [7:0] hi);
      return (b >= lo && b <= hi) ? 8'd1 : 8'd0;
   endfunction

   task automatic clear_text_state();
      space_owed = 1'b0;
      seq_len    = '0;
      seq_pos    = '0;
      bad_cont   = 1'b0;
      scalar_cnt = '0;
      byte_cnt   = '0;
      dropping   = 1'b0;
   endtask

   task automatic note_result(input logic [1:0] kind, input logic [7:0] data,
                              input logic [2:0] code);
      run_buf[run_len] = '{result_kind: kind, data_byte: data, error_code: code,
                           scalar_total: scalar_cnt, byte_total: byte_cnt,
                           last_of_run: 1'b0};
      run_len++;
   endtask

   // Works out every result that one accepted text byte causes.
   task automatic normalize_byte(input req_type r);
      logic [7:0] b;
      logic       eot;
      logic [2:0] err;
      logic [7:0] seq [4];
      int         len;
      int         pos;
      int         lead_len;
      int         sp;
      int         new_scalars;
      int         new_bytes;
      int         i;
      b       = r.in_byte;
      eot     = r.end_of_text;
      err     = ERR_NONE;
      len     = 0;
      run_len = 0;
      for (i = 0; i < 4; i++) seq[i] = 8'h00;

      if (dropping) begin
         if (eot) clear_text_state();
      end else begin
         if (seq_len != 0) begin
            // Any byte is taken into an open sequence; a non-continuation only marks it bad.
            pos = seq_pos;
            if (in_range(b, 8'h80, CONT_MAX) == 8'd0) bad_cont = 1'b1;
            if (pos < 3) seq_bytes[pos] = b;
            pos++;
            if (pos >= seq_len) begin
               len = seq_len;
               for (i = 0; i < len - 1; i++) seq[i] = seq_bytes[i];
               seq[len-1] = b;
               seq_len = '0;
               seq_pos = '0;
               if (bad_cont)
                  err = ERR_INVALID;
               else if ((len == 3 && seq[0] == LEAD3_MIN && seq[1] < E0_SECOND_MIN) ||
                        (len == 3 && seq[0] == LEAD_SURR && seq[1] > ED_SECOND_MAX) ||
                        (len == 4 && seq[0] == LEAD4_MIN && seq[1] < F0_SECOND_MIN) ||
                        (len == 4 && seq[0] == LEAD4_MAX && seq[1] > F4_SECOND_MAX))
                  err = ERR_NONSCALAR;
               else if (len == 2 && seq[0] == LEAD2_MIN && seq[1] <= C1_SECOND_MAX)
                  err = ERR_CONTROL;
               bad_cont = 1'b0;
            end else begin
               seq_pos = 3'(pos);
            end
         end else if (b <= ASCII_MAX) begin
            if ((b < CHAR_SPACE && b != CHAR_TAB && b != CHAR_LF && b != CHAR_CR) ||
                b == ASCII_MAX) begin
               err = ERR_CONTROL;
            end else if (b == CHAR_SPACE || b == CHAR_TAB || b == CHAR_LF || b == CHAR_CR) begin
               if (byte_cnt != 0) space_owed = 1'b1;
            end else begin
               len    = 1;
               seq[0] = b;
            end
         end else begin
            if (in_range(b, LEAD2_MIN, LEAD2_MAX) != 8'd0)      lead_len = 2;
            else if (in_range(b, LEAD3_MIN, LEAD3_MAX) != 8'd0) lead_len = 3;
            else if (in_range(b, LEAD4_MIN, LEAD4_MAX) != 8'd0) lead_len = 4;
            else                                                lead_len = 0;
            if (lead_len == 0) begin
               err = ERR_INVALID;
            end else begin
               seq_bytes[0] = b;
               seq_len      = 3'(lead_len);
               seq_pos      = 3'd1;
               bad_cont     = 1'b0;
            end
         end

         if (err == ERR_NONE && len != 0) begin
            sp          = space_owed ? 1 : 0;
            new_scalars = int'(scalar_cnt) + sp + 1;
            new_bytes   = int'(byte_cnt) + sp + len;
            // A scalar that would pass a limit is dropped whole, its space included.
            if (new_scalars > int'(lim_scalars) || new_bytes > int'(lim_bytes) ||
                new_scalars > COUNT_CEILING || new_bytes > COUNT_CEILING) begin
               err = ERR_TOO_LONG;
            end else begin
               if (space_owed) begin
                  scalar_cnt++;
                  byte_cnt++;
                  note_result(KIND_DATA, CHAR_SPACE, ERR_NONE);
                  space_owed = 1'b0;
               end
               for (i = 0; i < len; i++) begin
                  if (i == 0) scalar_cnt++;
                  byte_cnt++;
                  note_result(KIND_DATA, seq[i], ERR_NONE);
               end
            end
         end

         if (err == ERR_NONE && eot && seq_len != 0) err = ERR_TRUNCATED;

         if (err != ERR_NONE) begin
            note_result(KIND_REJECT, 8'h00, err);
            clear_text_state();
            if (!eot) dropping = 1'b1;
         end else if (eot) begin
            if (byte_cnt == 0) note_result(KIND_REJECT, 8'h00, ERR_BLANK);
            else               note_result(KIND_DONE, 8'h00, ERR_NONE);
            clear_text_state();
         end

         if (run_len > 0) begin
            run_buf[run_len-1].last_of_run = 1'b1;
            for (i = 0; i < run_len; i++)
               normalized_results = {normalized_results, run_buf[i]};
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         lim_scalars = MAX_SCALARS_RESET;
         lim_bytes   = MAX_BYTES_RESET;
         for (int k = 0; k < 3; k++) seq_bytes[k] = 8'h00;
         clear_text_state();
         normalized_results.delete();
         mismatch_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_MAX_SCALARS: lim_scalars = csr_data;
               REG_MAX_BYTES:   lim_bytes   = csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) normalize_byte(req_item);
         if (rsp_valid && rsp_ready) begin
            if (normalized_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%0t: result with nothing expected: %s", $time, describe(rsp_item));
            end else begin
               want = normalized_results.pop_front();
               if (rsp_item.result_kind  !== want.result_kind  ||
                   rsp_item.data_byte    !== want.data_byte    ||
                   rsp_item.error_code   !== want.error_code   ||
                   rsp_item.scalar_total !== want.scalar_total ||
                   rsp_item.byte_total   !== want.byte_total   ||
                   rsp_item.last_of_run  !== want.last_of_run) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $display("%0t: result mismatch", $time);
                     $display("   expected %s", describe(want));
                     $display("   actual   %s", describe(rsp_item));
                  end
               end
            end
         end
      end
      outstanding = normalized_results.size();
   end

endmodule

### tb/utf8_validate_space_collapse_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for the UTF-8 validate and space collapse block: clock, reset, stimulus, verdict.
// Depends on u8vsc_pkg, the block's top level and u8vsc_checker, which compares the results.

module utf8_validate_space_collapse_top_tb;
   import u8vsc_pkg::*;

   // The longest quiet stretch of a correct run is a settle pause plus one gap and one stall.
   localparam int STALL_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 16;

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   req_type                   req_item  = '0;
   logic                      rsp_ready = 1'b0;
   logic                      csr_valid = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data  = '0;
   logic                      req_ready;
   logic                      rsp_valid;
   rsp_type                   rsp_item;
   logic                      csr_ready;

   int         error_total;
   int         results_owed;
   int         idle_pct = 20;
   int         stall_cycles;
   logic [7:0] text_buf [$];

   utf8_validate_space_collapse_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   u8vsc_checker result_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_item       (req_item),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_item       (rsp_item),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (error_total),
      .outstanding    (results_owed)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // The result side stalls in bursts whenever the current phase allows idling.
   initial begin
      forever begin
         @(negedge clock);
         if (!reset && $urandom_range(99) < idle_pct) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(5, 1)) @(negedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   function automatic logic [7:0] pick_byte(input int lo, input int hi);
      return 8'($urandom_range(hi, lo));
   endfunction

   task automatic add_byte(input logic [7:0] value);
      text_buf = {text_buf, value};
   endtask

   // Entered and left at a falling edge; valid stays high on return unless an idle gap or settle drops it.
   task automatic send_byte(input logic [7:0] value, input logic last);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(5, 1)) @(negedge clock);
      end
      req_item  <= '{in_byte: value, end_of_text: last};
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_text();
      foreach (text_buf[i]) send_byte(text_buf[i], i == text_buf.size() - 1);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (results_owed != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_limits(input logic [15:0] scalars, input logic [15:0] bytes);
      csr_index <= REG_MAX_SCALARS;
      csr_data  <= scalars;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_index <= REG_MAX_BYTES;
      csr_data  <= bytes;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Mostly well-formed text with random content, mixed with broken sequences and noise.
   task automatic build_text();
      int         units;
      int         pick;
      int         n;
      logic [7:0] lead;
      text_buf.delete();
      units = $urandom_range(8, 1);
      repeat (units) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            add_byte(pick_byte(8'h21, 8'h7E));
         end else if (pick < 55) begin
            case ($urandom_range(3))
               0:       add_byte(CHAR_SPACE);
               1:       add_byte(CHAR_TAB);
               2:       add_byte(CHAR_LF);
               default: add_byte(CHAR_CR);
            endcase
         end else if (pick < 75) begin
            n = $urandom_range(4, 2);
            if (n == 2) begin
               add_byte(pick_byte(LEAD2_MIN, LEAD2_MAX));
            end else if (n == 3) begin
               lead = pick_byte(LEAD3_MIN, LEAD3_MAX);
               add_byte(lead);
               if (lead == LEAD3_MIN)      add_byte(pick_byte(E0_SECOND_MIN, CONT_MAX));
               else if (lead == LEAD_SURR) add_byte(pick_byte(8'h80, ED_SECOND_MAX));
               else                        add_byte(pick_byte(8'h80, CONT_MAX));
            end else begin
               lead = pick_byte(LEAD4_MIN, LEAD4_MAX);
               add_byte(lead);
               if (lead == LEAD4_MIN)      add_byte(pick_byte(F0_SECOND_MIN, CONT_MAX));
               else if (lead == LEAD4_MAX) add_byte(pick_byte(8'h80, F4_SECOND_MAX));
               else                        add_byte(pick_byte(8'h80, CONT_MAX));
               add_byte(pick_byte(8'h80, CONT_MAX));
            end
            add_byte(pick_byte(8'h80, CONT_MAX));
         end else if (pick < 88) begin
            // Any lead with loose followers: overlong, surrogate, C1 and bad continuations.
            lead = pick_byte(LEAD2_MIN, LEAD4_MAX);
            n = (lead <= LEAD2_MAX) ? 2 : (lead <= LEAD3_MAX) ? 3 : 4;
            add_byte(lead);
            repeat (n - 1) begin
               if ($urandom_range(4) != 0) add_byte(pick_byte(8'h80, CONT_MAX));
               else                        add_byte(pick_byte(8'h00, 8'hFF));
            end
         end else begin
            add_byte(pick_byte(8'h00, 8'hFF));
         end
      end
      if ($urandom_range(9) == 0) begin
         lead = pick_byte(LEAD2_MIN, LEAD4_MAX);
         n = (lead <= LEAD2_MAX) ? 2 : (lead <= LEAD3_MAX) ? 3 : 4;
         add_byte(lead);
         repeat ($urandom_range(n - 2, 0)) add_byte(pick_byte(8'h80, CONT_MAX));
      end
   endtask

   task automatic run_random(input int budget);
      int sent;
      sent = 0;
      while (sent < budget) begin
         build_text();
         sent += text_buf.size();
         send_text();
      end
   endtask

   initial begin
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Directed texts under the reset limits.
      text_buf = {8'h20, 8'h41, 8'h09, 8'h62, 8'h0D};
      send_text();
      text_buf = {8'h00};
      send_text();
      text_buf = {8'h7F, 8'h41, 8'h41};
      send_text();
      text_buf = {8'hFF, 8'h80};
      send_text();
      text_buf = {8'hC2, 8'h9F};
      send_text();
      text_buf = {8'hED, 8'hA0, 8'h80};
      send_text();
      text_buf = {8'hC3, 8'h41};
      send_text();
      text_buf = {8'hE2, 8'h82};
      send_text();
      text_buf = {8'h0A, 8'h09};
      send_text();
      text_buf = {8'hF4, 8'h8F, 8'hBF, 8'hBF};
      send_text();
      settle();

      write_limits(16'hFFFF, 16'hFFFF);
      idle_pct = 30;
      run_random(12);
      settle();

      write_limits(16'd5, 16'd12);
      idle_pct = 15;
      run_random(8);
      settle();

      write_limits(16'd1, 16'd1);
      idle_pct = 0;
      run_random(6);
      settle();

      // A limit of zero rejects every scalar.
      write_limits(16'd0, 16'd0);
      idle_pct = 40;
      run_random(3);
      settle();

      write_limits(16'hFFFF, 16'd3);
      idle_pct = 20;
      run_random(4);
      settle();

      write_limits(16'd3, 16'hFFFF);
      run_random(4);
      settle();

      write_limits(MAX_SCALARS_RESET, MAX_BYTES_RESET);
      idle_pct = 0;
      run_random(8);
      settle();

      if (error_total == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
